### hdl/sct_pkg.sv
package sct_pkg;

	// default sizes
	localparam int LINE_BITS_DEF     = 16;
	localparam int COLUMN_BITS_DEF   = 12;
	localparam int KEYWORD_CHARS_DEF = 8;

	// longest keyword text
	localparam int KW_MAX_CHARS = 8;
	localparam int KW_COUNT     = 24;
	localparam int PAIR_COUNT   = 18;
	localparam int SINGLE_COUNT = 23;

	// token kinds
	localparam logic [6:0] K_EOF       = 7'd0;
	localparam logic [6:0] K_IDENT     = 7'd1;
	localparam logic [6:0] K_STRING    = 7'd2;
	localparam logic [6:0] K_BOOLLIT   = 7'd3;
	localparam logic [6:0] K_DOUBLELIT = 7'd4;
	localparam logic [6:0] K_INTLIT    = 7'd5;
	localparam logic [6:0] K_PAIR0     = 7'd24;
	localparam logic [6:0] K_SINGLE0   = 7'd42;
	localparam logic [6:0] K_ERROR     = 7'd65;

	// characters with a role of their own
	localparam logic [7:0] CH_HASH       = 8'h23;
	localparam logic [7:0] CH_QUOTE      = 8'h22;
	localparam logic [7:0] CH_BSLASH     = 8'h5c;
	localparam logic [7:0] CH_UNDERSCORE = 8'h5f;
	localparam logic [7:0] CH_DOT        = 8'h2e;
	localparam logic [7:0] CH_PLUS       = 8'h2b;
	localparam logic [7:0] CH_MINUS      = 8'h2d;
	localparam logic [7:0] CH_LF         = 8'h0a;
	localparam logic [7:0] CH_CR         = 8'h0d;

	typedef enum logic [7:0] {
		MODE_IDLE    = 8'b0000_0001,
		MODE_COMMENT = 8'b0000_0010,
		MODE_STRING  = 8'b0000_0100,
		MODE_ESCAPE  = 8'b0000_1000,
		MODE_OP      = 8'b0001_0000,
		MODE_WORD    = 8'b0010_0000,
		MODE_NUM     = 8'b0100_0000,
		MODE_NUMDOT  = 8'b1000_0000
	} lex_mode_t;

	typedef struct packed {
		logic [8*KW_MAX_CHARS-1:0] text;
		logic [3:0]                len;
		logic [6:0]                kind;
		logic [2:0]                iw;
		logic                      bv;
	} kw_entry_t;

	localparam kw_entry_t KW_TABLE [KW_COUNT] = '{
		'{64'("func"),     4'd4, 7'd6,  3'd0, 1'b0},
		'{64'("return"),   4'd6, 7'd7,  3'd0, 1'b0},
		'{64'("int"),      4'd3, 7'd8,  3'd0, 1'b0},
		'{64'("int8"),     4'd4, 7'd8,  3'd1, 1'b0},
		'{64'("int16"),    4'd5, 7'd8,  3'd2, 1'b0},
		'{64'("int32"),    4'd5, 7'd8,  3'd3, 1'b0},
		'{64'("int64"),    4'd5, 7'd8,  3'd4, 1'b0},
		'{64'("double"),   4'd6, 7'd9,  3'd0, 1'b0},
		'{64'("bool"),     4'd4, 7'd10, 3'd0, 1'b0},
		'{64'("string"),   4'd6, 7'd11, 3'd0, 1'b0},
		'{64'("void"),     4'd4, 7'd12, 3'd0, 1'b0},
		'{64'("if"),       4'd2, 7'd13, 3'd0, 1'b0},
		'{64'("else"),     4'd4, 7'd14, 3'd0, 1'b0},
		'{64'("for"),      4'd3, 7'd15, 3'd0, 1'b0},
		'{64'("in"),       4'd2, 7'd16, 3'd0, 1'b0},
		'{64'("break"),    4'd5, 7'd17, 3'd0, 1'b0},
		'{64'("continue"), 4'd8, 7'd18, 3'd0, 1'b0},
		'{64'("type"),     4'd4, 7'd19, 3'd0, 1'b0},
		'{64'("delete"),   4'd6, 7'd20, 3'd0, 1'b0},
		'{64'("defer"),    4'd5, 7'd21, 3'd0, 1'b0},
		'{64'("match"),    4'd5, 7'd22, 3'd0, 1'b0},
		'{64'("enum"),     4'd4, 7'd23, 3'd0, 1'b0},
		'{64'("true"),     4'd4, 7'd3,  3'd0, 1'b1},
		'{64'("false"),    4'd5, 7'd3,  3'd0, 1'b0}
	};

	localparam logic [8*2*PAIR_COUNT-1:0] PAIR_OPS =
		"+=-=*=/=&&||++--!===..<=>=%=&=|=^==>";
	localparam logic [8*SINGLE_COUNT-1:0] SINGLE_OPS = "+-*/()[]{};:?&|^=!.,<>%";

	// byte i of a keyword, counted from its first character
	function automatic logic [7:0] kw_byte(kw_entry_t e, int i);
		int sh;
		sh = 8 * (int'(e.len) - 1 - i);
		if (i >= int'(e.len))
			return 8'h00;
		return e.text[sh +: 8];
	endfunction

	function automatic logic is_digit(logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic is_alpha(logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
	endfunction

	function automatic logic is_blank(logic [7:0] c);
		return c == 8'h20 || c == 8'h09 || c == 8'h0b || c == 8'h0c || c == 8'h00;
	endfunction

	function automatic logic is_punct(logic [7:0] c);
		return (c >= 8'd33 && c <= 8'd47) || (c >= 8'd58 && c <= 8'd64) ||
			(c >= 8'd91 && c <= 8'd96) || (c >= 8'd123 && c <= 8'd126);
	endfunction

	// kind of a two-character operator, zero when none
	function automatic logic [6:0] pair_kind(logic [7:0] h, logic [7:0] c);
		logic [6:0] k;
		k = 7'd0;
		for (int i = 0; i < PAIR_COUNT; i++) begin
			if (k == 7'd0 && PAIR_OPS[8*(2*PAIR_COUNT-1-2*i) +: 8] == h &&
					PAIR_OPS[8*(2*PAIR_COUNT-2-2*i) +: 8] == c)
				k = K_PAIR0 + 7'(i);
		end
		return k;
	endfunction

	// first character of some two-character operator
	function automatic logic is_holdable(logic [7:0] h);
		logic f;
		f = 1'b0;
		for (int i = 0; i < PAIR_COUNT; i++) begin
			if (PAIR_OPS[8*(2*PAIR_COUNT-1-2*i) +: 8] == h)
				f = 1'b1;
		end
		return f;
	endfunction

	function automatic logic [6:0] single_kind(logic [7:0] h);
		logic [6:0] k;
		k = K_IDENT;
		for (int i = 0; i < SINGLE_COUNT; i++) begin
			if (k == K_IDENT && SINGLE_OPS[8*(SINGLE_COUNT-1-i) +: 8] == h)
				k = K_SINGLE0 + 7'(i);
		end
		return k;
	endfunction

endpackage

### hdl/source_code_tokenizer.sv
// Channel  Direction  Handshake          Payload
// input    in         in_valid/in_stall  source_char, end_of_input
// output   out        out_valid/out_stall token_kind, line_number, start_column,
//                                         end_column, int_width, bool_value, last
//
// One source byte per cycle while the result register can take it: an item is
// registered, lexed and its tokens (none, one or two) land in a two-slot result
// register. A token leaves one per cycle unless out_stall holds it.
// Reset clears the lexer to the start of line 1 with no pending token.
// A stalled output holds the input side once the result register cannot take more.
module source_code_tokenizer #(
	parameter int LINE_BITS     = sct_pkg::LINE_BITS_DEF,
	parameter int COLUMN_BITS   = sct_pkg::COLUMN_BITS_DEF,
	parameter int KEYWORD_CHARS = sct_pkg::KEYWORD_CHARS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [7:0]             source_char,
	input  logic                   end_of_input,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [6:0]             token_kind,
	output logic [LINE_BITS-1:0]   line_number,
	output logic [COLUMN_BITS-1:0] start_column,
	output logic [COLUMN_BITS-1:0] end_column,
	output logic [2:0]             int_width,
	output logic                   bool_value,
	output logic                   last
);

	localparam int LW = $clog2(KEYWORD_CHARS + 1);
	localparam int IW = $clog2(KEYWORD_CHARS);

	typedef logic [COLUMN_BITS-1:0] col_t;
	typedef logic [LINE_BITS-1:0]   line_t;

	typedef struct packed {
		sct_pkg::lex_mode_t mode;
		logic [7:0]         held;
		logic               sp;
		col_t               tfc;
	} lstate_t;

	typedef struct packed {
		logic [6:0] kind;
		col_t       first_col;
		col_t       past_col;
		logic [2:0] iw;
		logic       bv;
	} res_t;

	typedef struct packed {
		lstate_t st;
		logic    emit;
		res_t    res;
		logic    cont;
		logic    start_w;
		logic    ext_w;
		logic    ovf;
	} pass_t;

	function automatic col_t sat_col(col_t x);
		return (&x) ? x : x + col_t'(1);
	endfunction

	function automatic res_t mk_res(logic [6:0] k, col_t a, col_t b, logic [2:0] iw,
			logic bv);
		res_t r;
		r.kind      = k;
		r.first_col = a;
		r.past_col  = b;
		r.iw        = iw;
		r.bv        = bv;
		return r;
	endfunction

	// one step of the lexer on one character
	function automatic pass_t lex_pass(lstate_t st, logic [7:0] c, col_t col, col_t prev,
			res_t wres, logic wfull);
		pass_t p;
		logic [6:0] pk;
		logic [6:0] nk;
		p    = '0;
		p.st = st;
		pk   = sct_pkg::pair_kind(st.held, c);
		nk   = st.sp ? sct_pkg::K_DOUBLELIT : sct_pkg::K_INTLIT;
		unique case (st.mode)
			sct_pkg::MODE_IDLE: begin
				if (!sct_pkg::is_blank(c)) begin
					p.st.tfc = col;
					if (c == sct_pkg::CH_HASH) begin
						p.st.mode = sct_pkg::MODE_COMMENT;
					end else if (c == sct_pkg::CH_QUOTE) begin
						p.st.mode = sct_pkg::MODE_STRING;
					end else if (sct_pkg::is_holdable(c)) begin
						p.st.held = c;
						p.st.mode = sct_pkg::MODE_OP;
					end else if (sct_pkg::is_punct(c)) begin
						p.emit = 1'b1;
						p.res  = mk_res(sct_pkg::single_kind(c), col, sat_col(col), 3'd0, 1'b0);
					end else if (sct_pkg::is_alpha(c)) begin
						p.start_w = 1'b1;
						p.st.mode = sct_pkg::MODE_WORD;
					end else if (sct_pkg::is_digit(c)) begin
						p.st.sp   = 1'b0;
						p.st.mode = sct_pkg::MODE_NUM;
					end else begin
						p.emit = 1'b1;
						p.res  = mk_res(sct_pkg::K_ERROR, col, sat_col(col), 3'd0, 1'b0);
					end
				end
			end
			sct_pkg::MODE_COMMENT: begin
				p.st.mode = sct_pkg::MODE_COMMENT;
			end
			sct_pkg::MODE_STRING: begin
				if (c == sct_pkg::CH_QUOTE) begin
					p.emit    = 1'b1;
					p.res     = mk_res(sct_pkg::K_STRING, st.tfc, sat_col(col), 3'd0, 1'b0);
					p.st.mode = sct_pkg::MODE_IDLE;
				end else if (c == sct_pkg::CH_BSLASH) begin
					p.st.mode = sct_pkg::MODE_ESCAPE;
				end
			end
			sct_pkg::MODE_ESCAPE: begin
				p.st.mode = sct_pkg::MODE_STRING;
			end
			sct_pkg::MODE_OP: begin
				if ((st.held == sct_pkg::CH_PLUS || st.held == sct_pkg::CH_MINUS) &&
						(sct_pkg::is_digit(c) || c == sct_pkg::CH_DOT)) begin
					p.st.sp   = 1'b0;
					p.st.mode = sct_pkg::MODE_NUM;
					p.cont    = 1'b1;
				end else if (st.held == sct_pkg::CH_DOT && sct_pkg::is_digit(c)) begin
					p.st.sp   = 1'b1;
					p.st.mode = sct_pkg::MODE_NUM;
					p.cont    = 1'b1;
				end else if (pk != 7'd0) begin
					p.emit    = 1'b1;
					p.res     = mk_res(pk, st.tfc, sat_col(col), 3'd0, 1'b0);
					p.st.mode = sct_pkg::MODE_IDLE;
				end else begin
					p.emit    = 1'b1;
					p.res     = mk_res(sct_pkg::single_kind(st.held), st.tfc, sat_col(st.tfc),
						3'd0, 1'b0);
					p.st.mode = sct_pkg::MODE_IDLE;
					p.cont    = 1'b1;
				end
			end
			sct_pkg::MODE_WORD: begin
				if (sct_pkg::is_alpha(c) || sct_pkg::is_digit(c) ||
						c == sct_pkg::CH_UNDERSCORE) begin
					if (wfull)
						p.ovf = 1'b1;
					else
						p.ext_w = 1'b1;
				end else begin
					p.emit    = 1'b1;
					p.res     = mk_res(wres.kind, st.tfc, col, wres.iw, wres.bv);
					p.st.mode = sct_pkg::MODE_IDLE;
					p.cont    = 1'b1;
				end
			end
			sct_pkg::MODE_NUM: begin
				if (sct_pkg::is_digit(c) || c == sct_pkg::CH_UNDERSCORE) begin
					p.st.mode = sct_pkg::MODE_NUM;
				end else if (c == sct_pkg::CH_DOT && !st.sp) begin
					p.st.held = sct_pkg::CH_DOT;
					p.st.mode = sct_pkg::MODE_NUMDOT;
				end else begin
					p.emit    = 1'b1;
					p.res     = mk_res(nk, st.tfc, col, 3'd0, 1'b0);
					p.st.mode = sct_pkg::MODE_IDLE;
					p.cont    = 1'b1;
				end
			end
			sct_pkg::MODE_NUMDOT: begin
				if (c == sct_pkg::CH_DOT) begin
					// back off: the held point starts a new operator
					p.emit    = 1'b1;
					p.res     = mk_res(nk, st.tfc, prev, 3'd0, 1'b0);
					p.st.tfc  = prev;
					p.st.held = sct_pkg::CH_DOT;
					p.st.mode = sct_pkg::MODE_OP;
					p.cont    = 1'b1;
				end else begin
					p.st.sp   = 1'b1;
					p.st.mode = sct_pkg::MODE_NUM;
					p.cont    = 1'b1;
				end
			end
			default: begin
				p.st.mode = sct_pkg::MODE_IDLE;
				p.cont    = 1'b1;
			end
		endcase
		return p;
	endfunction

	// input register
	logic       s1_valid_q;
	logic [7:0] ch_s1;
	logic       eoi_s1;

	// lexer state
	lstate_t                          st_q;
	line_t                            line_q;
	col_t                             col_q;
	logic [KEYWORD_CHARS-1:0][7:0]    wbuf_q;
	logic [LW-1:0]                    wlen_q;
	logic                             wovf_q;

	// result register
	res_t       res_q [2];
	line_t      res_line_q;
	logic [1:0] res_n_q;
	logic       res_h_q;

	logic res_free;
	logic adv;
	logic in_fire;
	logic out_fire;

	// word lookup
	res_t wres;
	logic wfound;
	logic whit;

	// next state
	lstate_t       nst;
	line_t         n_line;
	col_t          n_col;
	logic [LW-1:0] n_len;
	logic          n_ovf;
	logic          wb_start;
	logic          wb_ext;
	res_t          rs [2];
	logic [1:0]    rcnt;
	col_t          ccol;
	col_t          fend;
	pass_t         pv;
	logic          go;

	assign res_free = (res_n_q == 2'd0) || (res_n_q == 2'd1 && !out_stall);
	assign adv      = s1_valid_q && res_free;
	assign in_stall = s1_valid_q && !res_free;
	assign in_fire  = in_valid && !in_stall;
	assign out_fire = out_valid && !out_stall;

	// match the held word against the keyword table
	always_comb begin
		wres   = mk_res(sct_pkg::K_IDENT, '0, '0, 3'd0, 1'b0);
		wfound = 1'b0;
		whit   = 1'b0;
		if (!wovf_q) begin
			for (int i = 0; i < sct_pkg::KW_COUNT; i++) begin
				whit = (wlen_q == LW'(sct_pkg::KW_TABLE[i].len));
				for (int j = 0; j < sct_pkg::KW_MAX_CHARS; j++) begin
					if (j < int'(sct_pkg::KW_TABLE[i].len) &&
							wbuf_q[j] != sct_pkg::kw_byte(sct_pkg::KW_TABLE[i], j))
						whit = 1'b0;
				end
				if (whit && !wfound) begin
					wfound    = 1'b1;
					wres.kind = sct_pkg::KW_TABLE[i].kind;
					wres.iw   = sct_pkg::KW_TABLE[i].iw;
					wres.bv   = sct_pkg::KW_TABLE[i].bv;
				end
			end
		end
	end

	// lex the registered item
	always_comb begin
		nst      = st_q;
		n_line   = line_q;
		n_col    = col_q;
		n_len    = wlen_q;
		n_ovf    = wovf_q;
		wb_start = 1'b0;
		wb_ext   = 1'b0;
		rs[0]    = '0;
		rs[1]    = '0;
		rcnt     = 2'd0;
		ccol     = sat_col(col_q);
		fend     = ccol;
		pv       = '0;
		go       = 1'b0;
		if (eoi_s1 || ch_s1 == sct_pkg::CH_LF || ch_s1 == sct_pkg::CH_CR) begin
			// flush the pending token
			unique case (st_q.mode)
				sct_pkg::MODE_OP: begin
					rs[0] = mk_res(sct_pkg::single_kind(st_q.held), st_q.tfc,
						sat_col(st_q.tfc), 3'd0, 1'b0);
					rcnt  = 2'd1;
				end
				sct_pkg::MODE_WORD: begin
					rs[0] = mk_res(wres.kind, st_q.tfc, fend, wres.iw, wres.bv);
					rcnt  = 2'd1;
				end
				sct_pkg::MODE_NUMDOT: begin
					rs[0] = mk_res(sct_pkg::K_DOUBLELIT, st_q.tfc, fend, 3'd0, 1'b0);
					rcnt  = 2'd1;
				end
				sct_pkg::MODE_NUM: begin
					rs[0] = mk_res(st_q.sp ? sct_pkg::K_DOUBLELIT : sct_pkg::K_INTLIT,
						st_q.tfc, fend, 3'd0, 1'b0);
					rcnt  = 2'd1;
				end
				sct_pkg::MODE_STRING, sct_pkg::MODE_ESCAPE: begin
					rs[0] = mk_res(sct_pkg::K_ERROR, st_q.tfc, fend, 3'd0, 1'b0);
					rcnt  = 2'd1;
				end
				default: begin
					rcnt = 2'd0;
				end
			endcase
			nst.mode = sct_pkg::MODE_IDLE;
			if (eoi_s1) begin
				rs[rcnt[0]] = mk_res(sct_pkg::K_EOF, fend, fend, 3'd0, 1'b0);
				rcnt        = rcnt + 2'd1;
				nst         = '{sct_pkg::MODE_IDLE, 8'h00, 1'b0, '0};
				n_line      = line_t'(1);
				n_col       = '0;
				n_len       = '0;
				n_ovf       = 1'b0;
			end else begin
				n_line = (&line_q) ? line_q : line_q + line_t'(1);
				n_col  = '0;
			end
		end else begin
			// run the character through up to three lexer steps
			n_col = ccol;
			go    = 1'b1;
			for (int k = 0; k < 3; k++) begin
				if (go) begin
					pv  = lex_pass(nst, ch_s1, ccol, col_q, wres,
						wlen_q >= LW'(KEYWORD_CHARS));
					nst = pv.st;
					if (pv.emit && rcnt != 2'd2) begin
						rs[rcnt[0]] = pv.res;
						rcnt        = rcnt + 2'd1;
					end
					if (pv.start_w)
						wb_start = 1'b1;
					if (pv.ext_w)
						wb_ext = 1'b1;
					if (pv.ovf)
						n_ovf = 1'b1;
					go = pv.cont;
				end
			end
			if (wb_start) begin
				n_len = LW'(1);
				n_ovf = 1'b0;
			end else if (wb_ext) begin
				n_len = wlen_q + LW'(1);
			end
		end
	end

	// load the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_fire) begin
			s1_valid_q <= 1'b1;
		end else if (adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			ch_s1  <= source_char;
			eoi_s1 <= end_of_input;
		end
	end

	// advance the lexer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= '{sct_pkg::MODE_IDLE, 8'h00, 1'b0, '0};
			line_q <= line_t'(1);
			col_q  <= '0;
			wlen_q <= '0;
			wovf_q <= 1'b0;
		end else if (adv) begin
			st_q   <= nst;
			line_q <= n_line;
			col_q  <= n_col;
			wlen_q <= n_len;
			wovf_q <= n_ovf;
		end
	end

	// write the word buffer
	always_ff @(posedge clk) begin
		if (adv && wb_start)
			wbuf_q[0] <= ch_s1;
		else if (adv && wb_ext)
			wbuf_q[wlen_q[IW-1:0]] <= ch_s1;
	end

	// hold results until each is transferred
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_n_q <= 2'd0;
			res_h_q <= 1'b0;
		end else if (adv && rcnt != 2'd0) begin
			res_n_q <= rcnt;
			res_h_q <= 1'b0;
		end else if (out_fire) begin
			res_n_q <= res_n_q - 2'd1;
			res_h_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && rcnt != 2'd0) begin
			res_q[0]   <= rs[0];
			res_q[1]   <= rs[1];
			res_line_q <= line_q;
		end
	end

	assign out_valid    = res_n_q != 2'd0;
	assign token_kind   = res_q[res_h_q].kind;
	assign line_number  = res_line_q;
	assign start_column = res_q[res_h_q].first_col;
	assign end_column   = res_q[res_h_q].past_col;
	assign int_width    = res_q[res_h_q].iw;
	assign bool_value   = res_q[res_h_q].bv;
	assign last         = res_n_q == 2'd1;

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && !res_free |=> s1_valid_q && $stable(ch_s1) && $stable(eoi_s1))
		else $error("input register changed while held");

	a_eoi_reset: assert property (@(posedge clk) disable iff (!arst_n)
		adv && eoi_s1 |=> line_q == line_t'(1) && col_q == '0 &&
			st_q.mode == sct_pkg::MODE_IDLE)
		else $error("end of input did not restart the lexer");

	a_two_head: assert property (@(posedge clk) disable iff (!arst_n)
		res_n_q == 2'd2 |-> !res_h_q)
		else $error("two results pending but head past first slot");

endmodule

### tb/sv/tokenizer_checker.sv
module tokenizer_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [7:0]  source_char,
	input  logic        end_of_input,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [6:0]  token_kind,
	input  logic [15:0] line_number,
	input  logic [11:0] start_column,
	input  logic [11:0] end_column,
	input  logic [2:0]  int_width,
	input  logic        bool_value,
	input  logic        last,
	output int          fail_count,
	output int          tokens_due
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int COL_MAX  = 4095;
	localparam int LINE_MAX = 65535;

	typedef struct {
		logic [6:0]  kind;
		logic [15:0] line;
		logic [11:0] first;
		logic [11:0] past;
		logic [2:0]  iw;
		logic        bv;
		logic        tail;
	} token_t;

	token_t token_q[$];
	token_t step_q[$];

	string kw_text [24] = '{"func", "return", "int", "int8", "int16", "int32", "int64",
		"double", "bool", "string", "void", "if", "else", "for", "in", "break",
		"continue", "type", "delete", "defer", "match", "enum", "true", "false"};
	int kw_kind [24] = '{6, 7, 8, 8, 8, 8, 8, 9, 10, 11, 12, 13, 14, 15, 16, 17,
		18, 19, 20, 21, 22, 23, 3, 3};
	int kw_iw [24] = '{0, 0, 0, 1, 2, 3, 4, 0, 0, 0, 0, 0, 0, 0, 0, 0,
		0, 0, 0, 0, 0, 0, 0, 0};
	string pair_text   = "+=-=*=/=&&||++--!===..<=>=%=&=|=^==>";
	string single_text = "+-*/()[]{};:?&|^=!.,<>%";

	// lexer copy
	sct_pkg::lex_mode_t mode;
	logic [7:0] held;
	logic [7:0] word_buf [8];
	int         word_len;
	bit         word_ovf;
	bit         seen_pt;
	int         line_cnt;
	int         col_cnt;
	int         first_col;
	int         shown;

	function automatic int sat_col(int x);
		return x > COL_MAX ? COL_MAX : x;
	endfunction

	function automatic bit dig(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit alpha(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic bit blank(logic [7:0] c);
		return c == " " || c == 8'd9 || c == 8'd11 || c == 8'd12 || c == 8'd0;
	endfunction

	function automatic bit punct(logic [7:0] c);
		return (c >= 33 && c <= 47) || (c >= 58 && c <= 64) || (c >= 91 && c <= 96) ||
			(c >= 123 && c <= 126);
	endfunction

	function automatic int pair_of(logic [7:0] h, logic [7:0] c);
		for (int i = 0; i < 18; i++)
			if (pair_text[2*i] == h && pair_text[2*i+1] == c)
				return 24 + i;
		return 0;
	endfunction

	function automatic bit opens_pair(logic [7:0] h);
		for (int i = 0; i < 18; i++)
			if (pair_text[2*i] == h)
				return 1;
		return 0;
	endfunction

	function automatic int single_of(logic [7:0] h);
		for (int i = 0; i < 23; i++)
			if (single_text[i] == h)
				return 42 + i;
		return int'(sct_pkg::K_IDENT);
	endfunction

	function automatic void add_token(int kind, int s, int e, int iw, int bv);
		token_t t;
		if (step_q.size() >= 3)
			return;
		t.kind  = 7'(kind);
		t.line  = 16'(line_cnt);
		t.first = 12'(s);
		t.past  = 12'(e);
		t.iw    = 3'(iw);
		t.bv    = 1'(bv);
		t.tail  = 1'b0;
		step_q.push_back(t);
	endfunction

	function automatic void add_word(int e);
		string w;
		w = "";
		for (int i = 0; i < word_len; i++)
			w = {w, string'(word_buf[i])};
		if (!word_ovf)
			for (int i = 0; i < 24; i++)
				if (kw_text[i] == w) begin
					add_token(kw_kind[i], first_col, e, kw_iw[i], i == 22);
					return;
				end
		add_token(int'(sct_pkg::K_IDENT), first_col, e, 0, 0);
	endfunction

	function automatic void add_number(int e);
		add_token(seen_pt ? int'(sct_pkg::K_DOUBLELIT) : int'(sct_pkg::K_INTLIT),
			first_col, e, 0, 0);
	endfunction

	function automatic void clear_lexer();
		mode     = sct_pkg::MODE_IDLE;
		held     = 8'd0;
		word_len = 0;
		word_ovf = 0;
		seen_pt  = 0;
		line_cnt = 1;
		col_cnt  = 0;
		first_col = 0;
	endfunction

	// close whatever token is open at a line end or end of input
	function automatic void flush_open();
		int e;
		e = sat_col(col_cnt + 1);
		case (mode)
			sct_pkg::MODE_OP: add_token(single_of(held), first_col, sat_col(first_col + 1), 0, 0);
			sct_pkg::MODE_WORD: add_word(e);
			sct_pkg::MODE_NUMDOT: begin
				seen_pt = 1;
				add_number(e);
			end
			sct_pkg::MODE_NUM: add_number(e);
			sct_pkg::MODE_STRING, sct_pkg::MODE_ESCAPE:
				add_token(int'(sct_pkg::K_ERROR), first_col, e, 0, 0);
			default: ;
		endcase
		mode = sct_pkg::MODE_IDLE;
	endfunction

	function automatic void lex_char(logic [7:0] c, int col, int prev);
		bit again;
		int k;
		again = 1;
		while (again) begin
			again = 0;
			case (mode)
				sct_pkg::MODE_IDLE: begin
					if (!blank(c)) begin
						first_col = col;
						if (c == sct_pkg::CH_HASH)
							mode = sct_pkg::MODE_COMMENT;
						else if (c == sct_pkg::CH_QUOTE)
							mode = sct_pkg::MODE_STRING;
						else if (opens_pair(c)) begin
							held = c;
							mode = sct_pkg::MODE_OP;
						end else if (punct(c))
							add_token(single_of(c), col, sat_col(col + 1), 0, 0);
						else if (alpha(c)) begin
							word_buf[0] = c;
							word_len = 1;
							word_ovf = 0;
							mode = sct_pkg::MODE_WORD;
						end else if (dig(c)) begin
							seen_pt = 0;
							mode = sct_pkg::MODE_NUM;
						end else
							add_token(int'(sct_pkg::K_ERROR), col, sat_col(col + 1), 0, 0);
					end
				end
				sct_pkg::MODE_STRING: begin
					if (c == sct_pkg::CH_QUOTE) begin
						add_token(int'(sct_pkg::K_STRING), first_col, sat_col(col + 1), 0, 0);
						mode = sct_pkg::MODE_IDLE;
					end else if (c == sct_pkg::CH_BSLASH)
						mode = sct_pkg::MODE_ESCAPE;
				end
				sct_pkg::MODE_ESCAPE: mode = sct_pkg::MODE_STRING;
				sct_pkg::MODE_OP: begin
					k = pair_of(held, c);
					if ((held == sct_pkg::CH_PLUS || held == sct_pkg::CH_MINUS) &&
							(dig(c) || c == sct_pkg::CH_DOT)) begin
						seen_pt = 0;
						mode = sct_pkg::MODE_NUM;
						again = 1;
					end else if (held == sct_pkg::CH_DOT && dig(c)) begin
						seen_pt = 1;
						mode = sct_pkg::MODE_NUM;
						again = 1;
					end else if (k != 0) begin
						add_token(k, first_col, sat_col(col + 1), 0, 0);
						mode = sct_pkg::MODE_IDLE;
					end else begin
						add_token(single_of(held), first_col, sat_col(first_col + 1), 0, 0);
						mode = sct_pkg::MODE_IDLE;
						again = 1;
					end
				end
				sct_pkg::MODE_WORD: begin
					if (alpha(c) || dig(c) || c == sct_pkg::CH_UNDERSCORE) begin
						if (word_len < 8)
							word_buf[word_len++] = c;
						else
							word_ovf = 1;
					end else begin
						add_word(col);
						mode = sct_pkg::MODE_IDLE;
						again = 1;
					end
				end
				sct_pkg::MODE_NUM: begin
					if (c == sct_pkg::CH_DOT && !seen_pt) begin
						held = sct_pkg::CH_DOT;
						mode = sct_pkg::MODE_NUMDOT;
					end else if (!(dig(c) || c == sct_pkg::CH_UNDERSCORE)) begin
						add_number(col);
						mode = sct_pkg::MODE_IDLE;
						again = 1;
					end
				end
				sct_pkg::MODE_NUMDOT: begin
					// back off: the number ends before the first point
					if (c == sct_pkg::CH_DOT) begin
						add_number(prev);
						first_col = prev;
						held = sct_pkg::CH_DOT;
						mode = sct_pkg::MODE_OP;
					end else begin
						seen_pt = 1;
						mode = sct_pkg::MODE_NUM;
					end
					again = 1;
				end
				default: ;
			endcase
		end
	endfunction

	function automatic void predict_tokens(logic [7:0] c, logic eoi);
		int prev;
		int e;
		step_q.delete();
		if (eoi) begin
			flush_open();
			e = sat_col(col_cnt + 1);
			add_token(int'(sct_pkg::K_EOF), e, e, 0, 0);
			clear_lexer();
		end else if (c == sct_pkg::CH_LF || c == sct_pkg::CH_CR) begin
			flush_open();
			line_cnt = line_cnt >= LINE_MAX ? LINE_MAX : line_cnt + 1;
			col_cnt = 0;
		end else begin
			prev = col_cnt;
			col_cnt = sat_col(prev + 1);
			lex_char(c, col_cnt, prev);
		end
		if (step_q.size() > 0)
			step_q[step_q.size()-1].tail = 1'b1;
		foreach (step_q[i])
			token_q.push_back(step_q[i]);
	endfunction

	initial begin
		clear_lexer();
		fail_count = 0;
		shown = 0;
		tokens_due = 0;
	end

	// predict on each input transfer, compare on each output transfer
	always @(posedge clk) begin
		token_t x;
		if (arst_n) begin
			if (in_valid && !in_stall)
				predict_tokens(source_char, end_of_input);
			if (out_valid && !out_stall) begin
				if (token_q.size() == 0) begin
					fail_count++;
					if (shown < 10) begin
						shown++;
						$display("unexpected token kind=%0d line=%0d at %0t",
							token_kind, line_number, $realtime);
					end
				end else begin
					x = token_q.pop_front();
					if (token_kind !== x.kind || line_number !== x.line ||
							start_column !== x.first || end_column !== x.past ||
							int_width !== x.iw || bool_value !== x.bv || last !== x.tail) begin
						fail_count++;
						if (shown < 10) begin
							shown++;
							$display("token mismatch at %0t: kind %0d/%0d line %0d/%0d",
								$realtime, x.kind, token_kind, x.line, line_number);
							$display("  cols %0d..%0d/%0d..%0d iw %0d/%0d bv %0d/%0d last %0d/%0d",
								x.first, x.past, start_column, end_column, x.iw, int_width,
								x.bv, bool_value, x.tail, last);
						end
					end
				end
			end
			tokens_due <= token_q.size();
		end
	end

endmodule

### tb/sv/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  source_char = 8'd0;
	logic        end_of_input = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [6:0]  token_kind;
	logic [15:0] line_number;
	logic [11:0] start_column;
	logic [11:0] end_column;
	logic [2:0]  int_width;
	logic        bool_value;
	logic        last;
	int          fail_count;
	int          tokens_due;

	bit calm = 0;
	bit hold_req = 0;
	int sent;

	string kw_pool [24] = '{"func", "return", "int", "int8", "int16", "int32", "int64",
		"double", "bool", "string", "void", "if", "else", "for", "in", "break",
		"continue", "type", "delete", "defer", "match", "enum", "true", "false"};
	string op_pool = "+=-=*=/=&&||++--!===..<=>=%=&=|=^==>";
	string one_pool = "+-*/()[]{};:?&|^=!.,<>%@$~`'_";

	always #6 clk = ~clk;

	source_code_tokenizer dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.source_char(source_char), .end_of_input(end_of_input),
		.out_valid(out_valid), .out_stall(out_stall),
		.token_kind(token_kind), .line_number(line_number),
		.start_column(start_column), .end_column(end_column),
		.int_width(int_width), .bool_value(bool_value), .last(last)
	);

	tokenizer_checker chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.source_char(source_char), .end_of_input(end_of_input),
		.out_valid(out_valid), .out_stall(out_stall),
		.token_kind(token_kind), .line_number(line_number),
		.start_column(start_column), .end_column(end_column),
		.int_width(int_width), .bool_value(bool_value), .last(last),
		.fail_count(fail_count), .tokens_due(tokens_due)
	);

	// offer one byte and hold it until the transfer
	task automatic send_byte(logic [7:0] c, logic eoi);
		bit taken;
		while (!calm && $urandom_range(99) < 35) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		source_char  <= c;
		end_of_input <= eoi;
		do begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end while (!taken);
		sent++;
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i], 1'b0);
	endtask

	function automatic string rand_word(int n);
		string s;
		s = "";
		for (int i = 0; i < n; i++)
			case ($urandom_range(3))
				0: s = {s, string'(8'("0" + $urandom_range(9)))};
				1: s = {s, "_"};
				default: s = {s, string'(8'("a" + $urandom_range(25)))};
			endcase
		s[0] = 8'("A" + $urandom_range(25));
		return s;
	endfunction

	function automatic string rand_number();
		string s;
		s = "";
		case ($urandom_range(3))
			0: s = "-";
			1: s = "+";
			default: ;
		endcase
		repeat ($urandom_range(1, 4))
			s = {s, string'(8'($urandom_range(4) == 0 ? "_" : "0" + $urandom_range(9)))};
		case ($urandom_range(4))
			0: s = {s, "."};
			1: s = {s, ".", string'(8'("0" + $urandom_range(9)))};
			2: s = {s, "..", string'(8'("0" + $urandom_range(9)))};
			3: s = {s, ".5.", string'(8'("0" + $urandom_range(9)))};
			default: ;
		endcase
		return s;
	endfunction

	// one piece of random source text
	function automatic string rand_piece();
		string s;
		int k;
		case ($urandom_range(11))
			0, 1: s = kw_pool[$urandom_range(23)];
			2: s = rand_word($urandom_range(1, 11));
			3, 4: s = rand_number();
			5: begin
				s = "\"";
				repeat ($urandom_range(4))
					s = {s, $urandom_range(3) == 0 ? "\\\"" : string'(8'($urandom_range(32, 126)))};
				if ($urandom_range(5) != 0)
					s = {s, "\""};
			end
			6: begin
				k = $urandom_range(17);
				s = op_pool.substr(2*k, 2*k+1);
			end
			7: begin
				k = $urandom_range(one_pool.len() - 1);
				s = one_pool.substr(k, k);
			end
			8: s = {"# ", rand_word(3), "\n"};
			9: s = $urandom_range(1) ? "\n" : "\r";
			10: s = string'(8'($urandom_range(255)));
			default: s = "\t";
		endcase
		return s;
	endfunction

	// receiver: random stall, with one long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 0;
				out_stall <= 1'b1;
				repeat (300) @(posedge clk);
			end else
				out_stall <= (!calm && $urandom_range(99) < 35);
		end
	end

	initial begin
		#20ms;
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		sent = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// keywords, literals, back-off and the odd cases
		send_text("if int8 int64 true false continue abcdefghij x_9 _ @\n");
		send_text("12_3.5 1..2 -7 +.5 .5 7. 1.2.3 \"a\\\"b\" \"open\r");
		send_text("+=-=*=/=&&||++--!===..<=>=%=&=|=^==> +-*/()[]{};:?&|^=!.,<>%");
		send_byte(8'h80, 1'b0);
		send_byte(8'hff, 1'b0);
		send_byte(8'h7f, 1'b0);
		send_byte(8'h01, 1'b0);
		send_byte(8'h00, 1'b0);
		send_text("# note\n\"cut");
		send_byte(8'h00, 1'b1);
		send_text("\"s");
		send_byte(8'h00, 1'b1);
		send_text("ab");
		send_byte(8'h00, 1'b1);

		// random source with end marks now and then
		for (int n = 0; sent < 275; n++) begin
			string p;
			if (n == 4) begin
				in_valid <= 1'b0;
				@(posedge clk);
				wait (tokens_due == 0);
				repeat (8) @(posedge clk);
			end
			if (n == 8)
				hold_req = 1;
			calm = (n >= 12 && n < 20);
			p = rand_piece();
			send_text(p);
			if ($urandom_range(2) != 0)
				send_byte(" ", 1'b0);
			if ($urandom_range(24) == 0)
				send_byte(8'($urandom), 1'b1);
		end
		calm = 0;
		send_byte(8'h00, 1'b1);
		in_valid <= 1'b0;

		@(posedge clk);
		wait (tokens_due == 0);
		repeat (20) @(posedge clk);
		if (fail_count == 0 && tokens_due == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

### files.f
hdl/sct_pkg.sv
hdl/source_code_tokenizer.sv
tb/sv/tokenizer_checker.sv
tb/sv/tb.sv
